// File: rtl/mbbc_pkg.sv
// ----------------------------------------------------------------------------
// mbbc_pkg
// Types and constants shared by the memory block bounds checker modules.
// ----------------------------------------------------------------------------
package mbbc_pkg;

    localparam int unsigned CMD_LEN     = 9;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] OP_ADD     = 8'd0;
    localparam logic [7:0] OP_REMOVE  = 8'd1;
    localparam logic [7:0] OP_DISABLE = 8'd2;
    localparam logic [7:0] OP_ENABLE  = 8'd3;

    typedef struct packed {
        logic        operation;
        logic [7:0]  command_byte;
        logic [31:0] access_address;
        logic [7:0]  access_size;
    } t_in_item;

    typedef struct packed {
        logic access_ok;
        logic insert_dropped;
    } t_out_item;

    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_CMD,
        JOB_CHECK
    } t_job_kind;

    // One classified word from the front end. For a check, len holds the
    // access size; for a command, op/addr/len are the decoded command fields.
    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  op;
        logic [31:0] addr;
        logic [31:0] len;
    } t_job;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
    } t_region;

endpackage

// File: rtl/memory_block_bounds_checker_core.sv
// ----------------------------------------------------------------------------
// memory_block_bounds_checker_core
// Tracks allocated memory regions from nine-byte commands and checks accesses
// against them.
// ----------------------------------------------------------------------------
//  channel   handshake            payload                       direction
//  input     i_start / o_busy     i_item   (t_in_item)          in
//  result    o_done (strobe)      o_result (t_out_item)         out
//
// Every accepted word yields exactly one result word, in order.
// A word is accepted when i_start is high and o_busy is low; o_busy is high
// while the two-entry job queue is full.
// Command bytes, add, enable, disable and checks with checking off finish in
// the cycle the back end takes them; checks with checking on and removals
// scan the region table RAM one entry per cycle.
// The result appears on o_result for one cycle with o_done; it cannot be
// stalled. Reset is synchronous; the region table needs no clearing pass.
// ----------------------------------------------------------------------------
module memory_block_bounds_checker_core #(
    parameter int unsigned MAX_REGIONS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  mbbc_pkg::t_in_item  i_item,
    output logic                o_busy,
    output logic                o_done,
    output mbbc_pkg::t_out_item o_result
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    mbbc_pkg::t_job job_in;
    mbbc_pkg::t_job job_head;

    assign o_busy = full;
    assign accept = i_start && !full;

    mbbc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (push),
        .o_job    (job_in)
    );

    mbbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (job_head)
    );

    mbbc_back #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_job    (job_head),
        .o_pop    (pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// File: rtl/mbbc_ram.sv
// ----------------------------------------------------------------------------
// mbbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbbc_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mbbc_front.sv
// ----------------------------------------------------------------------------
// mbbc_front
// Front end: collects command bytes into nine-byte commands and classifies
// every accepted word into a job for the back end.
// ----------------------------------------------------------------------------
module mbbc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  mbbc_pkg::t_in_item i_item,
    output logic              o_push,
    output mbbc_pkg::t_job    o_job
);

    localparam logic [3:0] LAST_POS = 4'(mbbc_pkg::CMD_LEN - 1);

    logic [3:0]  r_pos;
    logic [63:0] r_cmd;
    logic [71:0] full_cmd;

    // The first eight bytes sit in the shift register; the ninth is the
    // byte arriving now.
    assign full_cmd = {r_cmd, i_item.command_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept && !i_item.operation) begin
            r_pos <= (r_pos == LAST_POS) ? 4'd0 : r_pos + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !i_item.operation) begin
            r_cmd <= {r_cmd[55:0], i_item.command_byte};
        end
    end

    always_comb begin
        o_job = '0;
        if (i_item.operation) begin
            o_job.kind = mbbc_pkg::JOB_CHECK;
            o_job.addr = i_item.access_address;
            o_job.len  = {24'd0, i_item.access_size};
        end else if (r_pos == LAST_POS) begin
            o_job.kind = mbbc_pkg::JOB_CMD;
            o_job.op   = full_cmd[71:64];
            o_job.addr = full_cmd[63:32];
            o_job.len  = full_cmd[31:0];
        end else begin
            o_job.kind = mbbc_pkg::JOB_BYTE;
        end
    end

    assign o_push = i_accept;

endmodule

// File: rtl/mbbc_fifo.sv
// ----------------------------------------------------------------------------
// mbbc_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mbbc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mbbc_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output mbbc_pkg::t_job o_head
);

    localparam int unsigned PW = (mbbc_pkg::QUEUE_DEPTH > 1) ?
                                 $clog2(mbbc_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(mbbc_pkg::QUEUE_DEPTH + 1);

    mbbc_pkg::t_job r_entry [mbbc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(mbbc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entry[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(mbbc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(mbbc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && o_full |-> i_pop)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job popped from an empty queue");

endmodule

// File: rtl/mbbc_back.sv
// ----------------------------------------------------------------------------
// mbbc_back
// Back end: executes jobs in order against the region table, scanning it one
// entry per cycle for removals and enabled checks, and drives the result strobe.
// ----------------------------------------------------------------------------
module mbbc_back #(
    parameter int unsigned MAX_REGIONS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  mbbc_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_done,
    output mbbc_pkg::t_out_item o_result
);

    localparam int unsigned AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int unsigned CW = $clog2(MAX_REGIONS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic                r_checking;
    logic [CW-1:0]       r_issue;
    logic                r_rd_vld;
    logic [CW-1:0]       r_wr_idx;
    logic                r_is_check;
    logic [31:0]         r_addr;
    logic [32:0]         r_hi;
    logic                r_hit;
    logic                r_done;
    mbbc_pkg::t_out_item r_result;
    logic                n_done;
    mbbc_pkg::t_out_item n_result;

    logic              table_full;
    logic              is_add;
    logic              scan_issue;
    logic              keep;
    logic              hit_now;
    logic [32:0]       region_end;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    mbbc_pkg::t_region ram_wdata;
    mbbc_pkg::t_region ram_rdata;

    assign o_pop      = (r_state == ST_IDLE) && !i_empty;
    assign table_full = (r_count >= CW'(MAX_REGIONS));
    assign is_add     = (i_job.kind == mbbc_pkg::JOB_CMD) && (i_job.op == mbbc_pkg::OP_ADD);
    assign scan_issue = (r_state == ST_SCAN) && (r_issue < r_count);

    assign region_end = {1'b0, ram_rdata.start} + {1'b0, ram_rdata.length};
    assign hit_now    = (r_addr >= ram_rdata.start) && (r_hi <= region_end);
    assign keep       = (ram_rdata.start != r_addr);

    // Removal compacts in place: the write index never passes the read index,
    // so every entry is read before it can be overwritten.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr_idx[AW-1:0];
        ram_wdata = ram_rdata;
        if (o_pop && is_add && !table_full) begin
            ram_we    = 1'b1;
            ram_waddr = r_count[AW-1:0];
            ram_wdata = '{start: i_job.addr, length: i_job.len};
        end else if ((r_state == ST_SCAN) && r_rd_vld && !r_is_check && keep) begin
            ram_we = 1'b1;
        end
    end

    // A job finishes either in the cycle it is taken or at the end of a scan.
    always_comb begin
        n_done   = 1'b0;
        n_result = r_result;
        if (o_pop) begin
            n_result = '0;
            unique case (i_job.kind)
                mbbc_pkg::JOB_CHECK: begin
                    if (!r_checking) begin
                        n_done             = 1'b1;
                        n_result.access_ok = 1'b1;
                    end
                end
                mbbc_pkg::JOB_CMD: begin
                    if (i_job.op != mbbc_pkg::OP_REMOVE) begin
                        n_done = 1'b1;
                        if ((i_job.op == mbbc_pkg::OP_ADD) && table_full) begin
                            n_result.insert_dropped = 1'b1;
                        end
                    end
                end
                default: begin
                    n_done = 1'b1;
                end
            endcase
        end else if ((r_state == ST_SCAN) && !scan_issue && !r_rd_vld) begin
            n_done   = 1'b1;
            n_result = '{access_ok: r_is_check && r_hit, insert_dropped: 1'b0};
        end
    end

    mbbc_ram #(
        .WIDTH ($bits(mbbc_pkg::t_region)),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (scan_issue),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_checking <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_done     <= 1'b0;
            r_result   <= '0;
        end else begin
            r_done   <= n_done;
            r_result <= n_result;
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_addr     <= i_job.addr;
                        r_hi       <= {1'b0, i_job.addr} + {1'b0, i_job.len};
                        r_hit      <= 1'b0;
                        r_issue    <= '0;
                        r_wr_idx   <= '0;
                        r_rd_vld   <= 1'b0;
                        r_is_check <= (i_job.kind == mbbc_pkg::JOB_CHECK);
                        unique case (i_job.kind)
                            mbbc_pkg::JOB_CHECK: begin
                                if (r_checking) begin
                                    r_state <= ST_SCAN;
                                end
                            end
                            mbbc_pkg::JOB_CMD: begin
                                if (i_job.op == mbbc_pkg::OP_REMOVE) begin
                                    r_state <= ST_SCAN;
                                end else if (i_job.op == mbbc_pkg::OP_ADD) begin
                                    if (!table_full) begin
                                        r_count <= r_count + CW'(1);
                                    end
                                end else if (i_job.op == mbbc_pkg::OP_DISABLE) begin
                                    r_checking <= 1'b0;
                                end else if (i_job.op == mbbc_pkg::OP_ENABLE) begin
                                    r_checking <= 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    r_rd_vld <= scan_issue;
                    if (scan_issue) begin
                        r_issue <= r_issue + CW'(1);
                    end
                    if (r_rd_vld) begin
                        if (r_is_check) begin
                            r_hit <= r_hit | hit_now;
                        end else if (keep) begin
                            r_wr_idx <= r_wr_idx + CW'(1);
                        end
                    end
                    if (!scan_issue && !r_rd_vld) begin
                        r_state <= ST_IDLE;
                        if (!r_is_check) begin
                            r_count <= r_wr_idx;
                        end
                    end
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_REGIONS))
        else $error("region count beyond table size");

    a_write_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_wr_idx <= r_issue))
        else $error("compaction write overtook the read index");

    a_drop_only_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.insert_dropped |-> !o_result.access_ok && !r_is_check)
        else $error("dropped flag on a check result");

    a_no_pop_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !o_pop)
        else $error("job taken while a scan is running");

endmodule
